// ----- hdl/tswe_pkg.sv -----
// tswe_pkg: shared types and constants of the touch scroll wheel emulator
// used by tswe_div and touch_scroll_wheel_emulator; no dependencies
package tswe_pkg;

    // contact state codes from the high nibble of record byte 7
    localparam logic [3:0] TS_START = 4'h3;
    localparam logic [3:0] TS_DRAG  = 4'h4;

    // divisor base: the divisor is SPEED_BASE minus the speed setting, times the acceleration factor
    localparam logic [6:0] SPEED_BASE = 7'd64;

    // configuration register indexes
    localparam logic [1:0] REG_SPEED   = 2'd0;
    localparam logic [1:0] REG_ENABLE  = 2'd1;
    localparam logic [1:0] REG_DEFAULT = 2'd2;
    localparam logic [1:0] REG_WINDOW  = 2'd3;

    // reset values of the configuration registers
    localparam logic [5:0]  SPEED_RST   = 6'd5;
    localparam logic [5:0]  DEFAULT_RST = 6'd1;
    localparam logic [15:0] WINDOW_RST  = 16'd125;

    // width of the divider magnitudes
    localparam int DIV_W = 12;

    typedef struct packed {
        logic                start;
        logic signed [12:0]  dividend;
        logic [DIV_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic signed [12:0]  quot;
        logic signed [12:0]  rem;
    } div_rsp_t;

endpackage

// ----- hdl/tswe_ram.sv -----
// tswe_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module tswe_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/tswe_div.sv -----
// tswe_div: serial restoring divider, one quotient bit a cycle, truncates toward zero
// depends on tswe_pkg
module tswe_div
    import tswe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CW = $clog2(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic             neg_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DIV_W-1:0] acc_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] dvs_reg;

    logic signed [12:0] mag_full;
    logic [DIV_W:0]     trial;
    logic               fits;
    logic [DIV_W:0]     trial_sub;

    // dividend magnitude and one restoring step
    always_comb
    begin
        mag_full  = req.dividend[12] ? (13'sd0 - req.dividend) : req.dividend;
        trial     = {acc_reg, quo_reg[DIV_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        trial_sub = trial - {1'b0, dvs_reg};
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIV_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.dividend[12];
            dvs_reg <= req.divisor;
            acc_reg <= '0;
            quo_reg <= mag_full[DIV_W-1:0];
        end
        else if (busy_reg)
        begin
            acc_reg <= fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    // signed results, remainder takes the sign of the dividend
    always_comb
    begin
        rsp.done = done_reg;
        rsp.quot = neg_reg ? (13'sd0 - $signed({1'b0, quo_reg})) : $signed({1'b0, quo_reg});
        rsp.rem  = neg_reg ? (13'sd0 - $signed({1'b0, acc_reg})) : $signed({1'b0, acc_reg});
    end

endmodule

// ----- hdl/touch_scroll_wheel_emulator.sv -----
// touch_scroll_wheel_emulator: finger records in, wheel steps out
// depends on tswe_pkg, tswe_ram and tswe_div
//
// Each accepted finger record gives exactly one result item. The slot's reference
// point (x and y) lives in a registered-read ram, read once per record and written
// back only on a touch start or a finished drag; per-slot valid bits make a
// never-written slot read as zero. A touch start stores the reference and steps the
// shared acceleration factor; a drag divides each axis difference by (64 - speed
// setting) * acceleration, truncating toward zero, in one shared serial divider that
// resolves one quotient bit a cycle and runs once per axis. A drag passes through the
// ram read, the divider for x and then for y, and the output load; any other record
// passes through the ram read and the output load. The next record is taken in the
// cycle after the result is handed to the output register, and that handover waits
// while an earlier result still blocks the output register. The next record is taken
// even while that result still waits to be taken.
module touch_scroll_wheel_emulator
    import tswe_pkg::*;
#(
    parameter int TOUCH_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // record input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: touch_byte0, touch_byte1, touch_byte2, touch_byte5,
    // touch_byte6, touch_byte7, now_ticks
    input  logic [79:0] s_axis_tdata,
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from bit 0: hwheel_delta, wheel_delta, zero fill
    output logic [31:0] m_axis_tdata,
    // tuser from bit 0: hwheel_valid, wheel_valid
    output logic [1:0]  m_axis_tuser
);

    localparam int SAW = (TOUCH_SLOTS > 1) ? $clog2(TOUCH_SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIVX,
        S_DIVY,
        S_DONE
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [5:0]  speed_reg;
    logic        enable_reg;
    logic [5:0]  default_reg;
    logic [15:0] window_reg;

    // shared state
    logic [5:0]  accel_reg;
    logic [31:0] last_reg;
    logic [TOUCH_SLOTS-1:0] slot_vld_reg;

    // current item
    logic signed [12:0] x_reg;
    logic signed [12:0] y_reg;
    logic [3:0]         slot_reg;
    logic [3:0]         kind_reg;
    logic [31:0]        now_reg;
    logic               slot_ok_reg;
    logic [DIV_W-1:0]   divisor_reg;
    logic signed [12:0] ref_y_reg;
    logic signed [12:0] qx_reg;
    logic signed [12:0] new_x_reg;

    // pending result
    logic               res_hv_reg;
    logic signed [12:0] res_hd_reg;
    logic               res_v_reg;
    logic signed [12:0] res_d_reg;

    // output register
    logic               out_vld_reg;
    logic               out_hv_reg;
    logic signed [12:0] out_hd_reg;
    logic               out_v_reg;
    logic signed [12:0] out_d_reg;

    // record decode
    logic [11:0]        in_x12;
    logic [11:0]        in_y12;
    logic signed [12:0] in_x;
    logic signed [12:0] in_y;
    logic [3:0]         in_slot;

    // ram ports
    logic           ram_we;
    logic [25:0]    ram_wdata;
    logic           ram_re;
    logic [25:0]    ram_rdata;
    logic [SAW-1:0] slot_idx;

    // datapath helpers
    logic signed [12:0] ref_x_rd;
    logic signed [12:0] ref_y_rd;
    logic [6:0]         base_minus;
    logic [5:0]         af_eff;
    logic [DIV_W-1:0]   prod;
    logic [31:0]        win_diff;
    logic               in_window;
    logic [5:0]         accel_step;
    logic signed [12:0] new_y;
    logic               out_load;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // field decode of the incoming record
    always_comb
    begin
        in_x12  = {s_axis_tdata[11:8], s_axis_tdata[7:0]};
        in_y12  = {s_axis_tdata[23:16], s_axis_tdata[15:12]};
        in_x    = $signed({in_x12[11], in_x12});
        in_y    = 13'sd0 - $signed({in_y12[11], in_y12});
        in_slot = {s_axis_tdata[33:32], s_axis_tdata[31:30]};
    end

    assign slot_idx = slot_reg[SAW-1:0];

    // reference read, a never-written slot reads as zero
    always_comb
    begin
        if (slot_vld_reg[slot_idx])
        begin
            ref_x_rd = $signed(ram_rdata[12:0]);
            ref_y_rd = $signed(ram_rdata[25:13]);
        end
        else
        begin
            ref_x_rd = 13'sd0;
            ref_y_rd = 13'sd0;
        end
    end

    // divisor and acceleration arithmetic
    always_comb
    begin
        base_minus = SPEED_BASE - {1'b0, speed_reg};
        af_eff     = (accel_reg == 6'd0) ? 6'd1 : accel_reg;
        prod       = {5'b0, base_minus} * {6'b0, af_eff};
        win_diff   = now_reg - (last_reg + {16'b0, window_reg});
        in_window  = win_diff[31];
        if (enable_reg && in_window)
        begin
            accel_step = (accel_reg > 6'd1) ? (accel_reg - 6'd1) : 6'd1;
        end
        else
        begin
            accel_step = (default_reg == 6'd0) ? 6'd1 : default_reg;
        end
        new_y = y_reg + div_rsp.rem;
    end

    // divider requests: x axis from the ram read, y axis once x is done
    always_comb
    begin
        div_req.divisor = divisor_reg;
        if (state_reg == S_EXEC)
        begin
            div_req.start    = slot_ok_reg && (kind_reg == TS_DRAG);
            div_req.dividend = ref_x_rd - x_reg;
        end
        else
        begin
            div_req.start    = (state_reg == S_DIVX) && div_rsp.done;
            div_req.dividend = ref_y_reg - y_reg;
        end
    end

    // ram access: read in S_READ, write back on a start or a finished drag
    always_comb
    begin
        ram_re = (state_reg == S_READ);
        ram_we = 1'b0;
        ram_wdata = {new_y, new_x_reg};
        if (state_reg == S_EXEC)
        begin
            ram_we    = slot_ok_reg && (kind_reg == TS_START);
            ram_wdata = {y_reg, x_reg};
        end
        else if (state_reg == S_DIVY)
        begin
            ram_we = div_rsp.done;
        end
    end

    tswe_ram #(
        .WIDTH (26),
        .DEPTH (TOUCH_SLOTS)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_idx),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_idx),
        .rdata (ram_rdata)
    );

    tswe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg   <= SPEED_RST;
            enable_reg  <= 1'b0;
            default_reg <= DEFAULT_RST;
            window_reg  <= WINDOW_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SPEED:   speed_reg   <= cfg_data[5:0];
                REG_ENABLE:  enable_reg  <= cfg_data[0];
                REG_DEFAULT: default_reg <= cfg_data[5:0];
                REG_WINDOW:  window_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ports
    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_load      = (state_reg == S_DONE) && (!out_vld_reg || m_axis_tready);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {6'b0, out_d_reg, out_hd_reg};
    assign m_axis_tuser  = {out_v_reg, out_hv_reg};

    // sequencer with shared state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            accel_reg    <= 6'd1;
            last_reg     <= '0;
            slot_vld_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            // output register handover
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (slot_ok_reg && (kind_reg == TS_START))
                    begin
                        accel_reg              <= accel_step;
                        slot_vld_reg[slot_idx] <= 1'b1;
                        state_reg              <= S_DONE;
                    end
                    else if (slot_ok_reg && (kind_reg == TS_DRAG))
                    begin
                        state_reg <= S_DIVX;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DIVX:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_DIVY;
                    end
                end
                S_DIVY:
                begin
                    if (div_rsp.done)
                    begin
                        slot_vld_reg[slot_idx] <= 1'b1;
                        if ((qx_reg != 13'sd0) || (div_rsp.quot != 13'sd0))
                        begin
                            last_reg <= now_reg;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // item payload and result payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            x_reg    <= in_x;
            y_reg    <= in_y;
            slot_reg <= in_slot;
            kind_reg <= s_axis_tdata[47:44];
            now_reg  <= s_axis_tdata[79:48];
        end
        if (state_reg == S_READ)
        begin
            slot_ok_reg <= {1'b0, slot_reg} < 5'(TOUCH_SLOTS);
            divisor_reg <= prod;
        end
        if (state_reg == S_EXEC)
        begin
            ref_y_reg  <= ref_y_rd;
            res_hv_reg <= 1'b0;
            res_hd_reg <= 13'sd0;
            res_v_reg  <= 1'b0;
            res_d_reg  <= 13'sd0;
        end
        if ((state_reg == S_DIVX) && div_rsp.done)
        begin
            qx_reg     <= div_rsp.quot;
            new_x_reg  <= x_reg + div_rsp.rem;
            res_hv_reg <= div_rsp.quot != 13'sd0;
            res_hd_reg <= 13'sd0 - div_rsp.quot;
        end
        if ((state_reg == S_DIVY) && div_rsp.done)
        begin
            res_v_reg <= div_rsp.quot != 13'sd0;
            res_d_reg <= div_rsp.quot;
        end
        if (out_load)
        begin
            out_hv_reg <= res_hv_reg;
            out_hd_reg <= res_hd_reg;
            out_v_reg  <= res_v_reg;
            out_d_reg  <= res_d_reg;
        end
    end

    // checks on the sequencer and datapath
    a_accel_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        accel_reg != 6'd0)
        else $error("acceleration factor reached zero");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIVX || state_reg == S_DIVY))
        else $error("divider finished outside a drag");

    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> ((!m_axis_tuser[0] || m_axis_tdata[12:0] != 13'd0)
                   && (!m_axis_tuser[1] || m_axis_tdata[25:13] != 13'd0)))
        else $error("wheel step flagged with zero delta");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_EXEC || state_reg == S_DIVY))
        else $error("reference written outside an item");

endmodule
